// ===== sv/pfs_pkg.sv =====
// Package for the palette fade stepper: item types, command codes and
// colour word layout. No dependencies.
`default_nettype none

package pfs_pkg;

    localparam int CMD_W    = 3;
    localparam int ACTOR_W  = 4;
    localparam int ENTRY_W  = 8;
    localparam int COLOUR_W = 16;
    localparam int LEN_W    = 9;
    localparam int MASK_W   = 14;
    localparam int CH_W     = 5;
    localparam int CH_N     = 3;

    localparam logic [CMD_W-1:0] CMD_WR_DRAWN  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WR_TARGET = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SET_LEN   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_START     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK      = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ      = 3'd5;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [ACTOR_W-1:0]  actor;
        logic [ENTRY_W-1:0]  entry;
        logic [COLOUR_W-1:0] colour;
        logic [LEN_W-1:0]    length;
    } pfs_req_t;

    typedef struct packed {
        logic [COLOUR_W-1:0] read_colour;
        logic [MASK_W-1:0]   fading_mask;
    } pfs_res_t;

    // outcome of stepping one stored entry toward its target
    typedef struct packed {
        logic                wr;
        logic                moved;
        logic [COLOUR_W-1:0] word;
    } pfs_step_t;

endpackage

`default_nettype wire

// ===== sv/palette_fade_stepper_unit.sv =====
// Palette fade stepper: drawn and target palettes in two RAMs, a fade walker
// and the command decode. Depends on pfs_pkg, pfs_ram and pfs_step.
//
// Usage: present an item on request with start high; it is taken at the
// clock edge where start is high and busy is low. Every item gives exactly
// one result on result, marked by done for a single cycle; the receiver
// cannot stall it, so it must take the result in that cycle.
// Writes, length, start fade, read and unused commands: result in the cycle
// after acceptance, one item per cycle, busy stays low.
// Frame tick: busy rises and the walker visits each actor in turn, and for
// each fading actor reads and writes back its first length entries through
// the RAMs' single read port, one entry per cycle. done comes with the last
// edge of the walk and busy drops at that same edge.
// Reset clears the lengths, the fading mask and the sequencer; palette
// contents are left as they are and must be written before use.
`default_nettype none

module palette_fade_stepper_unit
    import pfs_pkg::*;
#(
    parameter int ACTORS  = 14,
    parameter int ENTRIES = 256
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire pfs_req_t request,
    output logic          done,
    output pfs_res_t      result
);

    localparam int DEPTH = ACTORS * ENTRIES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int AIW   = (ACTORS > 1) ? $clog2(ACTORS) : 1;

    localparam logic [AIW-1:0]   LAST_ACTOR = AIW'(ACTORS - 1);
    localparam logic [LEN_W-1:0] MAX_LEN    = LEN_W'(ENTRIES);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ACTOR = 2'd1;
    localparam logic [1:0] S_WALK  = 2'd2;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [AIW-1:0]    actor_reg;
    logic [LEN_W-1:0]  k_reg;
    logic              pend_reg;
    logic [AW-1:0]     pend_addr_reg;
    logic              moved_reg;
    logic [ACTORS-1:0] fade_reg;
    logic [LEN_W-1:0]  len_reg [ACTORS];
    logic              done_reg;
    logic              rd_sel_reg;

    logic              accept;
    logic              actor_ok;
    logic              entry_ok;
    logic [AW-1:0]     in_addr;
    logic [AW-1:0]     walk_addr;
    logic [LEN_W-1:0]  cur_len;
    logic              issue;
    logic              walk_end;

    logic              drawn_we;
    logic [AW-1:0]     drawn_waddr;
    logic [COLOUR_W-1:0] drawn_wdata;
    logic              target_we;
    logic [AW-1:0]     raddr;
    logic [COLOUR_W-1:0] drawn_rdata;
    logic [COLOUR_W-1:0] target_rdata;
    pfs_step_t         step;
    logic [MASK_W-1:0] mask_out;

    assign busy     = state_reg != S_IDLE;
    assign accept   = start && !busy;
    assign actor_ok = int'(request.actor) < ACTORS;
    assign entry_ok = int'(request.entry) < ENTRIES;
    assign in_addr  = AW'(request.actor[AIW-1:0]) * AW'(ENTRIES) + AW'(request.entry);
    assign walk_addr = AW'(actor_reg) * AW'(ENTRIES) + AW'(k_reg);
    assign cur_len  = len_reg[actor_reg];
    assign issue    = k_reg < cur_len;
    assign walk_end = !issue && !pend_reg;

    assign raddr       = busy ? walk_addr : in_addr;
    assign drawn_we    = busy ? (state_reg == S_WALK && pend_reg && step.wr)
                              : (accept && request.cmd == CMD_WR_DRAWN && actor_ok && entry_ok);
    assign drawn_waddr = busy ? pend_addr_reg : in_addr;
    assign drawn_wdata = busy ? step.word : request.colour;
    assign target_we   = accept && request.cmd == CMD_WR_TARGET && actor_ok && entry_ok;

    pfs_ram #(
        .WIDTH (COLOUR_W),
        .DEPTH (DEPTH)
    ) u_drawn (
        .clk   (clk),
        .we    (drawn_we),
        .waddr (drawn_waddr),
        .wdata (drawn_wdata),
        .raddr (raddr),
        .rdata (drawn_rdata)
    );

    pfs_ram #(
        .WIDTH (COLOUR_W),
        .DEPTH (DEPTH)
    ) u_target (
        .clk   (clk),
        .we    (target_we),
        .waddr (in_addr),
        .wdata (request.colour),
        .raddr (raddr),
        .rdata (target_rdata)
    );

    pfs_step u_step (
        .now  (drawn_rdata),
        .want (target_rdata),
        .step (step)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && request.cmd == CMD_TICK)
                begin
                    state_next = S_ACTOR;
                end
            end
            S_ACTOR:
            begin
                if (fade_reg[actor_reg])
                begin
                    state_next = S_WALK;
                end
                else if (actor_reg == LAST_ACTOR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_WALK:
            begin
                if (walk_end)
                begin
                    state_next = (actor_reg == LAST_ACTOR) ? S_IDLE : S_ACTOR;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            actor_reg     <= '0;
            k_reg         <= '0;
            pend_reg      <= 1'b0;
            pend_addr_reg <= '0;
            moved_reg     <= 1'b0;
            fade_reg      <= '0;
            done_reg      <= 1'b0;
            rd_sel_reg    <= 1'b0;
            for (int i = 0; i < ACTORS; i++)
            begin
                len_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        rd_sel_reg <= request.cmd == CMD_READ && actor_ok && entry_ok;
                        actor_reg  <= '0;
                        if (request.cmd != CMD_TICK)
                        begin
                            done_reg <= 1'b1;
                        end
                        if (request.cmd == CMD_SET_LEN && actor_ok)
                        begin
                            len_reg[request.actor[AIW-1:0]] <=
                                (request.length > MAX_LEN) ? MAX_LEN : request.length;
                        end
                        if (request.cmd == CMD_START && actor_ok)
                        begin
                            fade_reg[request.actor[AIW-1:0]] <= 1'b1;
                        end
                    end
                end
                S_ACTOR:
                begin
                    rd_sel_reg <= 1'b0;
                    if (fade_reg[actor_reg])
                    begin
                        fade_reg[actor_reg] <= 1'b0;
                        k_reg     <= '0;
                        pend_reg  <= 1'b0;
                        moved_reg <= 1'b0;
                    end
                    else if (actor_reg == LAST_ACTOR)
                    begin
                        done_reg <= 1'b1;
                    end
                    else
                    begin
                        actor_reg <= actor_reg + AIW'(1);
                    end
                end
                S_WALK:
                begin
                    // read entry k while writing back the one read last cycle
                    pend_reg <= issue;
                    if (issue)
                    begin
                        k_reg         <= k_reg + LEN_W'(1);
                        pend_addr_reg <= walk_addr;
                    end
                    if (pend_reg && step.moved)
                    begin
                        moved_reg <= 1'b1;
                    end
                    if (walk_end)
                    begin
                        fade_reg[actor_reg] <= moved_reg;
                        if (actor_reg == LAST_ACTOR)
                        begin
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            actor_reg <= actor_reg + AIW'(1);
                        end
                    end
                end
                default:
                begin
                    rd_sel_reg <= 1'b0;
                end
            endcase
        end
    end

    for (genvar i = 0; i < MASK_W; i++)
    begin : g_mask
        if (i < ACTORS)
        begin : g_used
            assign mask_out[i] = fade_reg[i];
        end
        else
        begin : g_spare
            assign mask_out[i] = 1'b0;
        end
    end

    assign done               = done_reg;
    assign result.read_colour = rd_sel_reg ? drawn_rdata : '0;
    assign result.fading_mask = mask_out;

endmodule

`default_nettype wire

// ===== sv/pfs_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module pfs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 3584
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/pfs_step.sv =====
// Fade step for one colour word: moves each 5-bit channel one step toward
// the target and flags the entry. Depends on pfs_pkg.
`default_nettype none

module pfs_step
    import pfs_pkg::*;
(
    input  wire logic [COLOUR_W-1:0] now,
    input  wire logic [COLOUR_W-1:0] want,
    output pfs_step_t                step
);

    logic [CH_N-1:0]      ch_diff;
    logic [CH_W*CH_N-1:0] ch_new;

    always_comb
    begin
        for (int i = 0; i < CH_N; i++)
        begin
            ch_diff[i]            = now[i*CH_W +: CH_W] != want[i*CH_W +: CH_W];
            ch_new[i*CH_W +: CH_W] = now[i*CH_W +: CH_W];
            if (ch_diff[i])
            begin
                if (now[i*CH_W +: CH_W] < want[i*CH_W +: CH_W])
                begin
                    ch_new[i*CH_W +: CH_W] = now[i*CH_W +: CH_W] + CH_W'(1);
                end
                else
                begin
                    ch_new[i*CH_W +: CH_W] = now[i*CH_W +: CH_W] - CH_W'(1);
                end
            end
        end
        // a difference in the flag bit alone rewrites but does not count as movement
        step.wr    = now != want;
        step.moved = |ch_diff;
        step.word  = {1'b1, ch_new};
    end

endmodule

`default_nettype wire

// ===== sv/pfs_checker.sv =====
// Port-level checks for palette_fade_stepper_unit, bound to the top level.
// Depends on pfs_pkg.
`default_nettype none

module pfs_port_checker
    import pfs_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     start,
    input wire logic     busy,
    input wire pfs_req_t request,
    input wire logic     done,
    input wire pfs_res_t result
);

    // every item other than a tick answers in the next cycle
    a_quick_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.cmd != CMD_TICK) |=> done)
        else $error("no result one cycle after a non-tick item");

    // a tick holds off intake while the walk runs
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.cmd == CMD_TICK) |=> (busy || done))
        else $error("tick neither walking nor finished");

    // a result only follows an accepted item or a running walk
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(start && !busy) || $past(busy)))
        else $error("result without a cause");

    // only reads carry colour
    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.cmd != CMD_READ) |=> (result.read_colour == '0))
        else $error("colour on a result that is not a read");

endmodule

bind palette_fade_stepper_unit pfs_port_checker u_pfs_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
);

`default_nettype wire

// ===== bench/pfs_checker.sv =====
`timescale 1ns / 100ps
// Result checker for palette_fade_stepper_unit: mirrors both palettes, the
// lengths and the fading mask, predicts each item's result and compares it.
// Depends on pfs_pkg.
module pfs_checker
    import pfs_pkg::*;
#(
    parameter int ACTORS  = 14,
    parameter int ENTRIES = 256
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire logic     busy,
    input  wire pfs_req_t request,
    input  wire logic     done,
    input  wire pfs_res_t result,
    output int            errors,
    output int            pending,
    output int            checked
);

    logic [COLOUR_W-1:0] drawn_pal  [ACTORS*ENTRIES];
    logic [COLOUR_W-1:0] target_pal [ACTORS*ENTRIES];
    logic [LEN_W-1:0]    len_of     [ACTORS];
    logic [MASK_W-1:0]   fading;
    pfs_res_t            mask_reads_due [$];
    pfs_res_t            oldest;

    initial
    begin
        errors  = 0;
        pending = 0;
        checked = 0;
    end

    // one fade step of a colour word: each channel one count toward its target
    function automatic logic [COLOUR_W-1:0] nudge_word(input logic [COLOUR_W-1:0] now,
                                                       input logic [COLOUR_W-1:0] want,
                                                       output logic moved);
        logic [COLOUR_W-1:0] word;
        logic [CH_W-1:0]     cur;
        logic [CH_W-1:0]     tgt;
        word  = '0;
        moved = 1'b0;
        for (int ch = 0; ch < CH_N; ch++)
        begin
            cur = now[ch*CH_W +: CH_W];
            tgt = want[ch*CH_W +: CH_W];
            if (cur != tgt)
            begin
                moved = 1'b1;
                cur   = (cur < tgt) ? cur + 1'b1 : cur - 1'b1;
            end
            word[ch*CH_W +: CH_W] = cur;
        end
        // a rewritten entry always carries the flag
        word[COLOUR_W-1] = 1'b1;
        return word;
    endfunction

    function automatic pfs_res_t step_palettes(input pfs_req_t r);
        pfs_res_t res;
        int       idx;
        int       slot;
        logic     in_range;
        logic     moved;
        logic     any_moved;
        res      = '0;
        in_range = (r.actor < ACTORS) && (r.entry < ENTRIES);
        idx      = r.actor * ENTRIES + r.entry;
        case (r.cmd)
            CMD_WR_DRAWN:
                if (in_range)
                    drawn_pal[idx] = r.colour;
            CMD_WR_TARGET:
                if (in_range)
                    target_pal[idx] = r.colour;
            CMD_SET_LEN:
                if (r.actor < ACTORS)
                    len_of[r.actor] = (r.length > ENTRIES) ? LEN_W'(ENTRIES) : r.length;
            CMD_START:
                if (r.actor < ACTORS)
                    fading[r.actor] = 1'b1;
            CMD_TICK:
                for (int a = 0; a < ACTORS; a++)
                begin
                    if (fading[a])
                    begin
                        any_moved = 1'b0;
                        for (int k = 0; k < len_of[a]; k++)
                        begin
                            slot = a * ENTRIES + k;
                            if (drawn_pal[slot] != target_pal[slot])
                            begin
                                drawn_pal[slot] = nudge_word(drawn_pal[slot], target_pal[slot],
                                                             moved);
                                any_moved |= moved;
                            end
                        end
                        // a flag-only difference does not keep the actor fading
                        fading[a] = any_moved;
                    end
                end
            CMD_READ:
                if (in_range)
                    res.read_colour = drawn_pal[idx];
            default:
                ;
        endcase
        res.fading_mask = fading;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fading = '0;
            for (int a = 0; a < ACTORS; a++)
                len_of[a] = '0;
            mask_reads_due.delete();
        end
        else
        begin
            if (start && !busy)
                mask_reads_due.push_back(step_palettes(request));
            if (done)
            begin
                if (mask_reads_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with nothing awaited: colour %h mask %h",
                             $time, result.read_colour, result.fading_mask);
                end
                else
                begin
                    oldest = mask_reads_due.pop_front();
                    checked++;
                    if (result.read_colour !== oldest.read_colour)
                    begin
                        errors++;
                        $display("%0t: read_colour expected %h got %h",
                                 $time, oldest.read_colour, result.read_colour);
                    end
                    if (result.fading_mask !== oldest.fading_mask)
                    begin
                        errors++;
                        $display("%0t: fading_mask expected %h got %h",
                                 $time, oldest.fading_mask, result.fading_mask);
                    end
                end
            end
        end
        pending = mask_reads_due.size();
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Top of the palette fade stepper bench: clock, reset, command stimulus and
// the verdict. Depends on pfs_pkg, pfs_checker and palette_fade_stepper_unit.
module tb;
    import pfs_pkg::*;

    localparam int ACTORS       = 14;
    localparam int ENTRIES      = 256;
    localparam int ITEMS_WANTED = 1850;
    localparam int QUIET_LIMIT  = 40000;
    localparam int TAIL_CYCLES  = 20;
    localparam int GAP_PERCENT  = 38;

    localparam logic [CMD_W-1:0]    CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0]    CMD_SPARE_HI = 3'd7;
    localparam logic [ACTOR_W-1:0]  ACTOR_TOP    = '1;
    localparam logic [LEN_W-1:0]    LEN_MAX      = '1;
    localparam logic [ACTOR_W-1:0]  ACTOR_LAST   = ACTOR_W'(ACTORS - 1);
    localparam logic [ACTOR_W-1:0]  ACTOR_NONE   = ACTOR_W'(ACTORS);
    localparam logic [ENTRY_W-1:0]  ENTRY_LAST   = ENTRY_W'(ENTRIES - 1);
    // low two bits of each channel and the flag: targets a few steps away
    localparam logic [COLOUR_W-1:0] NEAR_FLIP    = 16'h8C63;

    logic     clk;
    logic     rst_n   = 1'b0;
    logic     start   = 1'b0;
    pfs_req_t request = '0;
    logic     busy;
    logic     done;
    pfs_res_t result;
    int       errors;
    int       pending;
    int       checked;

    bit drawn_set  [ACTORS][ENTRIES];
    bit target_set [ACTORS][ENTRIES];
    int sent   = 0;
    int ticks  = 0;
    int reads  = 0;
    int quiet  = 0;
    bit gappy  = 1'b1;

    palette_fade_stepper_unit #(.ACTORS(ACTORS), .ENTRIES(ENTRIES)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    pfs_checker #(.ACTORS(ACTORS), .ENTRIES(ENTRIES)) u_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result),
        .errors  (errors),
        .pending (pending),
        .checked (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy))
            quiet <= 0;
        else if (quiet == QUIET_LIMIT)
        begin
            $display("%0t: nothing accepted for %0d cycles", $time, QUIET_LIMIT);
            $display("tb NOT OK");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    function automatic pfs_req_t cmd_item(input logic [CMD_W-1:0] cmd,
                                          input logic [ACTOR_W-1:0] actor,
                                          input logic [ENTRY_W-1:0] entry,
                                          input logic [COLOUR_W-1:0] colour,
                                          input logic [LEN_W-1:0] length);
        pfs_req_t r;
        r.cmd    = cmd;
        r.actor  = actor;
        r.entry  = entry;
        r.colour = colour;
        r.length = length;
        return r;
    endfunction

    // an item with the given command and actor and every other field random
    function automatic pfs_req_t rand_item(input logic [CMD_W-1:0] cmd,
                                           input logic [ACTOR_W-1:0] actor);
        return cmd_item(cmd, actor, ENTRY_W'($urandom), COLOUR_W'($urandom),
                        LEN_W'($urandom));
    endfunction

    function automatic logic [COLOUR_W-1:0] near(input logic [COLOUR_W-1:0] c);
        if ($urandom_range(0, 2) == 0)
            return COLOUR_W'($urandom);
        return c ^ (COLOUR_W'($urandom) & NEAR_FLIP);
    endfunction

    // a length whose entries are all written in both palettes
    function automatic logic [LEN_W-1:0] pick_length(input int a);
        int lead;
        lead = 0;
        while (lead < ENTRIES && drawn_set[a][lead] && target_set[a][lead])
            lead++;
        if (lead == ENTRIES)
            return LEN_W'($urandom);
        return LEN_W'($urandom_range(0, lead));
    endfunction

    task automatic issue(input pfs_req_t r);
        while (gappy && $urandom_range(0, 99) < GAP_PERCENT)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy);
        sent++;
        if (r.actor < ACTORS && r.cmd == CMD_WR_DRAWN)
            drawn_set[r.actor][r.entry] = 1'b1;
        if (r.actor < ACTORS && r.cmd == CMD_WR_TARGET)
            target_set[r.actor][r.entry] = 1'b1;
        if (r.cmd == CMD_TICK)
            ticks++;
        if (r.cmd == CMD_READ)
            reads++;
    endtask

    task automatic hold_until_drained();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    initial
    begin
        pfs_req_t            r;
        logic [ACTOR_W-1:0]  a;
        int                  n;
        logic [COLOUR_W-1:0] c;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every command, flag-only difference, ignored actors
        issue(cmd_item(CMD_TICK, 0, 0, 0, 0));
        issue(cmd_item(CMD_WR_DRAWN, 0, 0, 16'h0000, 0));
        issue(cmd_item(CMD_WR_TARGET, 0, 0, 16'hFFFF, 0));
        issue(cmd_item(CMD_WR_DRAWN, 0, 1, 16'h8123, 0));
        issue(cmd_item(CMD_WR_TARGET, 0, 1, 16'h0123, 0));
        issue(cmd_item(CMD_WR_DRAWN, 0, ENTRY_LAST, 16'hFFFF, LEN_MAX));
        issue(cmd_item(CMD_SET_LEN, 0, 0, 0, 2));
        issue(cmd_item(CMD_START, 0, 0, 0, 0));
        issue(cmd_item(CMD_TICK, 0, 0, 0, 0));
        issue(cmd_item(CMD_READ, 0, 0, 0, 0));
        issue(cmd_item(CMD_READ, 0, 1, 0, 0));
        issue(cmd_item(CMD_TICK, 0, 0, 0, 0));
        issue(cmd_item(CMD_WR_DRAWN, ACTOR_LAST, 0, 16'h7C1F, 0));
        issue(cmd_item(CMD_WR_TARGET, ACTOR_LAST, 0, 16'h03E0, 0));
        issue(cmd_item(CMD_SET_LEN, ACTOR_LAST, 0, 0, 1));
        issue(cmd_item(CMD_START, ACTOR_LAST, 0, 0, 0));
        issue(cmd_item(CMD_TICK, 0, 0, 0, 0));
        issue(cmd_item(CMD_READ, ACTOR_LAST, 0, 0, 0));
        issue(cmd_item(CMD_WR_DRAWN, ACTOR_NONE, 0, 16'hFFFF, 0));
        issue(cmd_item(CMD_SET_LEN, ACTOR_TOP, ENTRY_LAST, 16'hFFFF, LEN_MAX));
        issue(cmd_item(CMD_START, ACTOR_TOP, 0, 0, 0));
        issue(cmd_item(CMD_READ, ACTOR_TOP, 0, 0, 0));
        issue(cmd_item(CMD_SPARE_LO, 0, 0, 0, 0));
        issue(cmd_item(CMD_SPARE_HI, ACTOR_TOP, ENTRY_LAST, 16'hFFFF, LEN_MAX));
        issue(cmd_item(CMD_READ, 0, ENTRY_LAST, 0, 0));
        hold_until_drained();

        // fill the last actor completely, back to back, then fade it with a
        // length at or above the palette size
        gappy = 1'b0;
        for (int e = 0; e < ENTRIES; e++)
        begin
            c = COLOUR_W'($urandom);
            issue(cmd_item(CMD_WR_DRAWN, ACTOR_LAST, ENTRY_W'(e), c, LEN_W'($urandom)));
            issue(cmd_item(CMD_WR_TARGET, ACTOR_LAST, ENTRY_W'(e), near(c),
                           LEN_W'($urandom)));
        end
        r = rand_item(CMD_SET_LEN, ACTOR_LAST);
        r.length = LEN_W'($urandom_range(ENTRIES, LEN_MAX));
        issue(r);
        issue(rand_item(CMD_START, ACTOR_LAST));
        repeat (4)
        begin
            issue(rand_item(CMD_TICK, ACTOR_W'($urandom)));
            issue(rand_item(CMD_READ, ACTOR_LAST));
        end
        gappy = 1'b1;
        hold_until_drained();

        while (sent < ITEMS_WANTED)
        begin
            if ($urandom_range(0, 99) < 65)
            begin
                // load a short palette, fade it and watch it move
                a = ACTOR_W'($urandom_range(0, ACTORS-1));
                n = $urandom_range(1, 12);
                for (int e = 0; e < n; e++)
                begin
                    c = COLOUR_W'($urandom);
                    issue(cmd_item(CMD_WR_DRAWN, a, ENTRY_W'(e), c, LEN_W'($urandom)));
                    issue(cmd_item(CMD_WR_TARGET, a, ENTRY_W'(e), near(c),
                                   LEN_W'($urandom)));
                end
                r = rand_item(CMD_SET_LEN, a);
                r.length = pick_length(int'(a));
                issue(r);
                issue(rand_item(CMD_START, a));
                repeat ($urandom_range(1, 6))
                begin
                    issue(rand_item(CMD_TICK, ACTOR_W'($urandom)));
                    r = rand_item(CMD_READ, a);
                    r.entry = ENTRY_W'($urandom_range(0, n-1));
                    issue(r);
                end
            end
            else
            begin
                r = rand_item(CMD_W'($urandom), ACTOR_W'($urandom));
                if (r.actor < ACTORS && r.cmd == CMD_SET_LEN)
                    r.length = pick_length(int'(r.actor));
                // steer reads of never-written entries to an absent actor
                if (r.actor < ACTORS && r.cmd == CMD_READ && !drawn_set[r.actor][r.entry])
                    r.actor = ACTOR_W'(ACTORS + $urandom_range(0, ACTOR_TOP - ACTORS));
                issue(r);
            end
            if ($urandom_range(0, 49) == 0)
                hold_until_drained();
        end

        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d commands sent (%0d frame ticks, %0d reads), %0d results compared",
                 sent, ticks, reads, checked);
        $display("one actor faded over its full %0d-entry palette, length saturation hit",
                 ENTRIES);
        if (errors == 0 && pending == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
